[rtl/icpef_pkg.sv]
package icpef_pkg;

    localparam int MAX_CLUSTERS = 32;
    localparam int CNT_W = $clog2(MAX_CLUSTERS + 1);
    localparam int IDX_W = $clog2(MAX_CLUSTERS);

    localparam int TIME_W = 16;
    localparam int ENERGY_W = 18;
    localparam int THR_W = 19;
    localparam int WIN_W = 16;
    localparam int DS_W = 16;
    localparam int TTYPE_W = 8;
    localparam int STAMP_W = 32;
    localparam int STEP_W = $clog2(STAMP_W);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 19;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_WINDOW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOWNSCALE_FACTOR = 2'd2;

    localparam logic [THR_W-1:0] RST_ENERGY_THRESHOLD = 19'd72000;
    localparam logic [WIN_W-1:0] RST_TIME_WINDOW = 16'd112;
    localparam logic [DS_W-1:0] RST_DOWNSCALE_FACTOR = 16'd1;

    localparam logic [TTYPE_W-1:0] PHYS_MASK_A = 8'h01;
    localparam logic [TTYPE_W-1:0] PHYS_MASK_B = 8'h10;

    typedef struct packed {
        logic accept;
        logic scan;
        logic store;
        logic div_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_present;
        logic in_last;
        logic count_nz;
        logic scan_end;
        logic last;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

[rtl/icpef_rem.sv]
module icpef_rem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [icpef_pkg::STAMP_W-1:0] i_dividend,
    input  logic [icpef_pkg::DS_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic                          o_rem_zero
);

    logic                          r_busy;
    logic                          r_done;
    logic [icpef_pkg::STEP_W-1:0]  r_step;
    logic [icpef_pkg::STAMP_W-1:0] r_num;
    logic [icpef_pkg::DS_W-1:0]    r_dsr;
    logic [icpef_pkg::DS_W:0]      r_rem;
    logic [icpef_pkg::DS_W:0]      n_trial;
    logic [icpef_pkg::DS_W:0]      n_rem;

    always_comb begin
        n_trial = {r_rem[icpef_pkg::DS_W-1:0], r_num[icpef_pkg::STAMP_W-1]};
        if (n_trial >= {1'b0, r_dsr}) begin
            n_rem = n_trial - {1'b0, r_dsr};
        end else begin
            n_rem = n_trial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == icpef_pkg::STEP_W'(icpef_pkg::STAMP_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num  <= i_dividend;
            r_dsr  <= (i_divisor == '0) ? icpef_pkg::DS_W'(1) : i_divisor;
            r_rem  <= '0;
            r_step <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[icpef_pkg::STAMP_W-2:0], 1'b0};
            r_rem  <= n_rem;
            r_step <= r_step + icpef_pkg::STEP_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_rem_zero = (r_rem == '0);

endmodule

[rtl/icpef_dp.sv]
module icpef_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  icpef_pkg::t_cmd                  i_cmd,
    output icpef_pkg::t_sts                  o_sts,
    input  logic                             i_cfg_we,
    input  logic [icpef_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [icpef_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                             i_in_valid,
    input  logic                             i_cluster_present,
    input  logic signed [icpef_pkg::TIME_W-1:0] i_cluster_time,
    input  logic [icpef_pkg::ENERGY_W-1:0]   i_cluster_energy,
    input  logic [icpef_pkg::TTYPE_W-1:0]    i_trigger_type,
    input  logic [icpef_pkg::STAMP_W-1:0]    i_event_timestamp,
    input  logic                             i_last_cluster,
    input  logic                             i_out_stall,
    output logic                             o_out_valid,
    output logic                             o_event_accepted,
    output logic                             o_physics_trigger,
    output logic                             o_pair_found,
    output logic                             o_cluster_overflow
);

    logic [icpef_pkg::THR_W-1:0] r_thr;
    logic [icpef_pkg::WIN_W-1:0] r_win;
    logic [icpef_pkg::DS_W-1:0]  r_ds;

    logic [icpef_pkg::TIME_W-1:0]   r_mem_t [icpef_pkg::MAX_CLUSTERS];
    logic [icpef_pkg::ENERGY_W-1:0] r_mem_e [icpef_pkg::MAX_CLUSTERS];

    logic [icpef_pkg::TIME_W-1:0]   r_rd_t;
    logic [icpef_pkg::ENERGY_W-1:0] r_rd_e;
    logic                           r_rd_valid;

    logic [icpef_pkg::TIME_W-1:0]   r_new_t;
    logic [icpef_pkg::ENERGY_W-1:0] r_new_e;
    logic [icpef_pkg::TTYPE_W-1:0]  r_ttype;
    logic [icpef_pkg::STAMP_W-1:0]  r_stamp;
    logic                           r_last;

    logic [icpef_pkg::CNT_W-1:0] r_count;
    logic [icpef_pkg::CNT_W-1:0] r_idx;
    logic                        r_pair;
    logic                        r_ovf;
    logic                        r_out_valid;

    logic                        n_room;
    logic signed [icpef_pkg::TIME_W:0] n_diff;
    logic [icpef_pkg::TIME_W:0]  n_adiff;
    logic [icpef_pkg::THR_W-1:0] n_sum;
    logic                        n_hit;
    logic                        n_phys;
    logic [icpef_pkg::STAMP_W-1:0] n_dividend;
    logic                        div_done;
    logic                        rem_zero;

    assign n_room = (r_count < icpef_pkg::CNT_W'(icpef_pkg::MAX_CLUSTERS));

    // an empty last request starts the remainder in its accept cycle
    assign n_dividend = i_cmd.accept ? i_event_timestamp : r_stamp;

    always_comb begin
        n_diff  = $signed({r_new_t[icpef_pkg::TIME_W-1], r_new_t})
                - $signed({r_rd_t[icpef_pkg::TIME_W-1], r_rd_t});
        n_adiff = n_diff[icpef_pkg::TIME_W] ? 17'(-n_diff) : 17'(n_diff);
        n_sum   = {1'b0, r_new_e} + {1'b0, r_rd_e};
        n_hit   = (n_adiff < {1'b0, r_win}) && (n_sum > r_thr);
        n_phys  = ((r_ttype & icpef_pkg::PHYS_MASK_A) != '0)
               || ((r_ttype & icpef_pkg::PHYS_MASK_B) != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= icpef_pkg::RST_ENERGY_THRESHOLD;
            r_win <= icpef_pkg::RST_TIME_WINDOW;
            r_ds  <= icpef_pkg::RST_DOWNSCALE_FACTOR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                icpef_pkg::REG_ENERGY_THRESHOLD: begin
                    r_thr <= i_cfg_wdata;
                end
                icpef_pkg::REG_TIME_WINDOW: begin
                    r_win <= i_cfg_wdata[icpef_pkg::WIN_W-1:0];
                end
                icpef_pkg::REG_DOWNSCALE_FACTOR: begin
                    r_ds <= i_cfg_wdata[icpef_pkg::DS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_new_t <= i_cluster_time;
            r_new_e <= i_cluster_energy;
            r_ttype <= i_trigger_type;
            r_stamp <= i_event_timestamp;
            r_last  <= i_last_cluster;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && n_room) begin
            r_mem_t[r_count[icpef_pkg::IDX_W-1:0]] <= r_new_t;
            r_mem_e[r_count[icpef_pkg::IDX_W-1:0]] <= r_new_e;
        end
        if (i_cmd.scan) begin
            r_rd_t <= r_mem_t[r_idx[icpef_pkg::IDX_W-1:0]];
            r_rd_e <= r_mem_e[r_idx[icpef_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_idx <= '0;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + icpef_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pair      <= 1'b0;
            r_ovf       <= 1'b0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.scan;
            if (i_cmd.out_load) begin
                r_count <= '0;
                r_pair  <= 1'b0;
                r_ovf   <= 1'b0;
            end else begin
                if (r_rd_valid && n_hit) begin
                    r_pair <= 1'b1;
                end
                if (i_cmd.store) begin
                    if (n_room) begin
                        r_count <= r_count + icpef_pkg::CNT_W'(1);
                    end else begin
                        r_ovf <= 1'b1;
                    end
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_event_accepted   <= n_phys && r_pair && rem_zero;
            o_physics_trigger  <= n_phys;
            o_pair_found       <= r_pair;
            o_cluster_overflow <= r_ovf;
        end
    end

    icpef_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_dividend),
        .i_divisor  (r_ds),
        .o_done     (div_done),
        .o_rem_zero (rem_zero)
    );

    assign o_out_valid = r_out_valid;

    always_comb begin
        o_sts.in_valid   = i_in_valid;
        o_sts.in_present = i_cluster_present;
        o_sts.in_last    = i_last_cluster;
        o_sts.count_nz   = (r_count != '0);
        o_sts.scan_end   = ((r_idx + icpef_pkg::CNT_W'(1)) == r_count);
        o_sts.last       = r_last;
        o_sts.div_done   = div_done;
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

endmodule

[rtl/icpef_ctrl.sv]
module icpef_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  icpef_pkg::t_sts i_sts,
    output icpef_pkg::t_cmd o_cmd,
    output logic            o_in_stall
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_FLUSH = 3'd2;
    localparam logic [2:0] S_STORE = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_sts.in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.in_present) begin
                        n_state = i_sts.count_nz ? S_SCAN : S_STORE;
                    end else if (i_sts.in_last) begin
                        o_cmd.div_start = 1'b1;
                        n_state = S_DIV;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_end) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_STORE;
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                if (i_sts.last) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

[rtl/intime_cluster_pair_energy_filter_core.sv]
// channel   direction  handshake                 payload
// in        request    i_in_valid / o_in_stall   present, time, energy, trigger, stamp, last
// out       result     o_out_valid / i_out_stall accepted, physics, pair, overflow
// cfg       write      i_cfg_we                  i_cfg_index, i_cfg_wdata
//
// One request at a time. A cluster scans the n > 0 stored clusters (one stored
// entry read per cycle from the cluster memory), then flushes and stores; with
// none it goes straight to the store step, and an empty request is only accepted.
// The last request adds the bit-serial timestamp remainder and a result load.
// Synchronous active-low reset; no memory clearing pass.
// The result sits in an output register; a stall there holds the block only
// when the next result is ready.
module intime_cluster_pair_energy_filter_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [icpef_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [icpef_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_cluster_present,
    input  logic signed [icpef_pkg::TIME_W-1:0] i_cluster_time,
    input  logic [icpef_pkg::ENERGY_W-1:0]   i_cluster_energy,
    input  logic [icpef_pkg::TTYPE_W-1:0]    i_trigger_type,
    input  logic [icpef_pkg::STAMP_W-1:0]    i_event_timestamp,
    input  logic                             i_last_cluster,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_event_accepted,
    output logic                             o_physics_trigger,
    output logic                             o_pair_found,
    output logic                             o_cluster_overflow
);

    icpef_pkg::t_cmd cmd;
    icpef_pkg::t_sts sts;

    icpef_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    icpef_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .i_cluster_present  (i_cluster_present),
        .i_cluster_time     (i_cluster_time),
        .i_cluster_energy   (i_cluster_energy),
        .i_trigger_type     (i_trigger_type),
        .i_event_timestamp  (i_event_timestamp),
        .i_last_cluster     (i_last_cluster),
        .i_out_stall        (i_out_stall),
        .o_out_valid        (o_out_valid),
        .o_event_accepted   (o_event_accepted),
        .o_physics_trigger  (o_physics_trigger),
        .o_pair_found       (o_pair_found),
        .o_cluster_overflow (o_cluster_overflow)
    );

endmodule

[sim/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASES = 7;
    localparam int ITEMS_PER_PHASE = 270;
    localparam int LONG_HOLD = 300;
    localparam logic [icpef_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic accepted;
        logic physics;
        logic pair;
        logic overflow;
    } t_verdict;

    typedef struct packed {
        logic                                present;
        logic signed [icpef_pkg::TIME_W-1:0] cl_time;
        logic [icpef_pkg::ENERGY_W-1:0]      energy;
        logic [icpef_pkg::TTYPE_W-1:0]       ttype;
        logic [icpef_pkg::STAMP_W-1:0]       stamp;
        logic                                last;
        logic                                typed;
        t_verdict                            want;
    } t_cluster_req;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_we;
    logic [icpef_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [icpef_pkg::CFG_DATA_W-1:0]    i_cfg_wdata;
    logic                                i_in_valid;
    logic                                o_in_stall;
    logic                                i_cluster_present;
    logic signed [icpef_pkg::TIME_W-1:0] i_cluster_time;
    logic [icpef_pkg::ENERGY_W-1:0]      i_cluster_energy;
    logic [icpef_pkg::TTYPE_W-1:0]       i_trigger_type;
    logic [icpef_pkg::STAMP_W-1:0]       i_event_timestamp;
    logic                                i_last_cluster;
    logic                                o_out_valid;
    logic                                i_out_stall;
    logic                                o_event_accepted;
    logic                                o_physics_trigger;
    logic                                o_pair_found;
    logic                                o_cluster_overflow;

    intime_cluster_pair_energy_filter_core dut (.*);

    // filter model state
    logic [icpef_pkg::THR_W-1:0]         thr_reg = icpef_pkg::RST_ENERGY_THRESHOLD;
    logic [icpef_pkg::WIN_W-1:0]         win_reg = icpef_pkg::RST_TIME_WINDOW;
    logic [icpef_pkg::DS_W-1:0]          ds_reg = icpef_pkg::RST_DOWNSCALE_FACTOR;
    logic signed [icpef_pkg::TIME_W-1:0] held_time [icpef_pkg::MAX_CLUSTERS];
    logic [icpef_pkg::ENERGY_W-1:0]      held_energy [icpef_pkg::MAX_CLUSTERS];
    int                                  held_count = 0;
    bit                                  pair_flag = 0;
    bit                                  overflow_flag = 0;

    t_verdict verdict_q [$];
    t_verdict seen_want;
    t_verdict seen_got;

    t_cluster_req plan [16];

    int  errors = 0;
    int  n_requests = 0;
    int  n_events = 0;
    int  n_accepted = 0;
    int  n_paired = 0;
    int  n_overflowed = 0;
    int  cycle_count = 0;
    bit  quiet = 0;
    bit  long_hold_req = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     verdict_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic bit filter_step(input t_cluster_req r, output t_verdict v);
        int       t_new;
        int       t_old;
        int       diff;
        int       esum;
        bit       keep;
        logic [icpef_pkg::STAMP_W-1:0] ds_eff;
        v = '0;
        if (r.present) begin
            t_new = r.cl_time;
            for (int i = 0; i < held_count; i++) begin
                t_old = held_time[i];
                diff = t_new - t_old;
                if (diff < 0)
                    diff = -diff;
                esum = int'(r.energy) + int'(held_energy[i]);
                if (diff < int'(win_reg) && esum > int'(thr_reg))
                    pair_flag = 1;
            end
            if (held_count < icpef_pkg::MAX_CLUSTERS) begin
                held_time[held_count] = r.cl_time;
                held_energy[held_count] = r.energy;
                held_count++;
            end else begin
                overflow_flag = 1;
            end
        end
        if (!r.last)
            return 0;
        ds_eff = (ds_reg == '0) ? 32'd1 : 32'(ds_reg);
        keep = (r.stamp % ds_eff) == 0;
        v.physics = ((r.ttype & icpef_pkg::PHYS_MASK_A) != 0)
                 || ((r.ttype & icpef_pkg::PHYS_MASK_B) != 0);
        v.pair = pair_flag;
        v.overflow = overflow_flag;
        v.accepted = v.physics && pair_flag && keep;
        held_count = 0;
        pair_flag = 0;
        overflow_flag = 0;
        return 1;
    endfunction

    function automatic void check_field(input string name, input logic want, input logic got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
        end
    endfunction

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_got = '{o_event_accepted, o_physics_trigger, o_pair_found,
                         o_cluster_overflow};
            if (verdict_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %b", $time, seen_got);
            end else begin
                seen_want = verdict_q.pop_front();
                check_field("event_accepted", seen_want.accepted, seen_got.accepted);
                check_field("physics_trigger", seen_want.physics, seen_got.physics);
                check_field("pair_found", seen_want.pair, seen_got.pair);
                check_field("cluster_overflow", seen_want.overflow, seen_got.overflow);
                n_events++;
                n_accepted += seen_got.accepted;
                n_paired += seen_got.pair;
                n_overflowed += seen_got.overflow;
            end
        end
    end

    // result receiver
    initial begin
        int hold;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 0;
                hold = LONG_HOLD;
            end else begin
                hold = quiet ? 0 : $urandom_range(0, 4);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    task automatic send_request(input t_cluster_req r);
        int       gap;
        t_verdict v;
        @(negedge i_clk);
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_cluster_present <= r.present;
        i_cluster_time <= r.cl_time;
        i_cluster_energy <= r.energy;
        i_trigger_type <= r.ttype;
        i_event_timestamp <= r.stamp;
        i_last_cluster <= r.last;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        n_requests++;
        if (filter_step(r, v))
            verdict_q.push_back(r.typed ? r.want : v);
    endtask

    task automatic drain(input int settle);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [icpef_pkg::CFG_IDX_W-1:0] idx,
                             input logic [icpef_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            icpef_pkg::REG_ENERGY_THRESHOLD: thr_reg = data[icpef_pkg::THR_W-1:0];
            icpef_pkg::REG_TIME_WINDOW:      win_reg = data[icpef_pkg::WIN_W-1:0];
            icpef_pkg::REG_DOWNSCALE_FACTOR: ds_reg = data[icpef_pkg::DS_W-1:0];
            default: ;
        endcase
    endtask

    // one event: times near a base and energies near half the threshold, or random
    task automatic send_event(input int ncl);
        t_cluster_req r;
        int           base;
        int           tv;
        int           ev;
        int           ecenter;
        int           espread;
        int           tspread;
        bit           wide;
        logic [icpef_pkg::STAMP_W-1:0] ds_eff;
        wide = ($urandom_range(0, 7) == 0);
        base = int'($urandom_range(0, 65535)) - 32768;
        tspread = (win_reg < 16) ? 16 : int'(win_reg);
        ecenter = int'(thr_reg) / 2;
        espread = int'(thr_reg) / 8 + 16;
        ds_eff = (ds_reg == '0) ? 32'd1 : 32'(ds_reg);
        for (int k = 0; k < ncl; k++) begin
            r = '0;
            r.present = ($urandom_range(0, 9) != 0);
            if (wide) begin
                r.cl_time = 16'($urandom);
                r.energy = 18'($urandom);
            end else begin
                tv = base + int'($urandom_range(0, 2 * tspread)) - tspread;
                if (tv > 32767)
                    tv = 32767;
                if (tv < -32768)
                    tv = -32768;
                ev = ecenter + int'($urandom_range(0, 2 * espread)) - espread;
                if (ev > 262143)
                    ev = 262143;
                if (ev < 0)
                    ev = 0;
                r.cl_time = 16'(tv);
                r.energy = 18'(ev);
            end
            r.ttype = 8'($urandom);
            if ($urandom_range(0, 1))
                r.ttype = r.ttype | ($urandom_range(0, 1) ? icpef_pkg::PHYS_MASK_A
                                                          : icpef_pkg::PHYS_MASK_B);
            if ($urandom_range(0, 1))
                r.stamp = ds_eff * 32'($urandom_range(0, 32'hFFFF_FFFF / ds_eff));
            else
                r.stamp = $urandom;
            r.last = (k == ncl - 1);
            send_request(r);
        end
    endtask

    initial begin
        logic [icpef_pkg::THR_W-1:0] thr_set [PHASES];
        logic [icpef_pkg::WIN_W-1:0] win_set [PHASES];
        logic [icpef_pkg::DS_W-1:0]  ds_set [PHASES];
        int                          target;
        int                          ncl;
        bit                          paused;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_cluster_present = 1'b0;
        i_cluster_time = '0;
        i_cluster_energy = '0;
        i_trigger_type = '0;
        i_event_timestamp = '0;
        i_last_cluster = 1'b0;

        // present, time, energy, trigger, stamp, last, typed, {acc, phys, pair, ovf}
        plan = '{
            '{1'b0, 16'sd0, 18'd0, 8'h01, 32'd0, 1'b1, 1'b1, 4'b0100},
            '{1'b1, 16'sd0, 18'd40000, 8'h00, 32'd0, 1'b0, 1'b0, 4'b0000},
            '{1'b1, 16'sd100, 18'd40000, 8'h10, 32'd5, 1'b1, 1'b1, 4'b1110},
            '{1'b1, 16'sd0, 18'd40000, 8'h00, 32'd0, 1'b0, 1'b0, 4'b0000},
            '{1'b1, 16'sd112, 18'd40000, 8'h11, 32'd7, 1'b1, 1'b1, 4'b0100},
            '{1'b1, -16'sd5, 18'd36000, 8'h00, 32'd0, 1'b0, 1'b0, 4'b0000},
            '{1'b1, 16'sd5, 18'd36000, 8'h01, 32'd9, 1'b1, 1'b1, 4'b0100},
            '{1'b1, 16'h8000, 18'h3FFFF, 8'h00, 32'd0, 1'b0, 1'b0, 4'b0000},
            '{1'b1, 16'h7FFF, 18'h3FFFF, 8'hEE, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'b0000},
            '{1'b0, 16'h7FFF, 18'h3FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 4'b0000},
            '{1'b1, -16'sd1, 18'h3FFFF, 8'h00, 32'd0, 1'b0, 1'b0, 4'b0000},
            '{1'b1, 16'sd110, 18'd0, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 4'b1110},
            '{1'b1, 16'sd50, 18'd50000, 8'h00, 32'd0, 1'b0, 1'b0, 4'b0000},
            '{1'b1, -16'sd50, 18'd30000, 8'h80, 32'd3, 1'b1, 1'b1, 4'b0010},
            '{1'b1, 16'sd0, 18'd36000, 8'h00, 32'd0, 1'b0, 1'b0, 4'b0000},
            '{1'b1, 16'sd0, 18'd36001, 8'h10, 32'd0, 1'b1, 1'b1, 4'b1110}
        };

        thr_set = '{icpef_pkg::RST_ENERGY_THRESHOLD, 19'd0, 19'h7FFFF,
                    19'($urandom_range(40000, 140000)), 19'($urandom), 19'd1,
                    19'($urandom_range(10000, 300000))};
        win_set = '{icpef_pkg::RST_TIME_WINDOW, 16'hFFFF, 16'd0, 16'($urandom_range(16, 400)),
                    16'($urandom), 16'd1, 16'($urandom_range(0, 2000))};
        ds_set = '{icpef_pkg::RST_DOWNSCALE_FACTOR, 16'd0, 16'hFFFF, 16'($urandom_range(1, 3)),
                   16'($urandom_range(1, 8)), 16'd2, 16'($urandom_range(1, 65535))};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i])
            send_request(plan[i]);

        for (int p = 0; p < PHASES; p++) begin
            drain(80);
            write_reg(icpef_pkg::REG_ENERGY_THRESHOLD, thr_set[p]);
            write_reg(icpef_pkg::REG_TIME_WINDOW, {3'($urandom_range(0, 7)), win_set[p]});
            write_reg(icpef_pkg::REG_DOWNSCALE_FACTOR, {3'($urandom_range(0, 7)), ds_set[p]});
            if (p == 1)
                write_reg(REG_SPARE, 19'($urandom));
            quiet = (p == 5);
            if (p == 3)
                long_hold_req = 1;
            paused = 0;
            target = n_requests + ITEMS_PER_PHASE;
            while (n_requests < target) begin
                if (p == 4 && !paused && n_requests > target - ITEMS_PER_PHASE / 2) begin
                    paused = 1;
                    drain(0);
                end
                if ($urandom_range(0, 19) == 0)
                    ncl = $urandom_range(icpef_pkg::MAX_CLUSTERS - 1,
                                         icpef_pkg::MAX_CLUSTERS + 8);
                else
                    ncl = $urandom_range(1, 8);
                send_event(ncl);
            end
        end

        drain(80);
        $display("%0d requests in %0d events over %0d register settings", n_requests,
                 n_events, PHASES);
        $display("%0d events accepted, %0d with an in-time pair, %0d with storage overflow",
                 n_accepted, n_paired, n_overflowed);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
